// ===== rtl/multi_policy_process_scheduler_macros.svh =====
// assertion macros for the process scheduler
// no dependencies
`ifndef MULTI_POLICY_PROCESS_SCHEDULER_MACROS_SVH
`define MULTI_POLICY_PROCESS_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define MPS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("mps check failed");
`define MPS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("mps check failed");
`else
`define MPS_ASSERT(label, clk, rst_n, prop)
`define MPS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/mps_pkg.sv =====
// types and codes shared by the process scheduler modules
// no dependencies
`default_nettype none
package mps_pkg;
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_CREATE = 3'd1;
  localparam logic [2:0] REQ_BLOCK = 3'd2;
  localparam logic [2:0] REQ_WAKE  = 3'd3;
  localparam logic [2:0] REQ_TERM  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RUN  = 2'd1;
  localparam logic [1:0] ST_NOT_FND = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_NPRI = 2'd1;
  localparam logic [1:0] POL_PPRI = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_SLICE  = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] process_id;
    logic [2:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  assigned_id;
    logic        running_valid;
    logic [3:0]  running_id;
    logic [31:0] running_time;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/mps_front.sv =====
// front end: request queue between the port and the engine
// depends on mps_pkg
`default_nettype none
module mps_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mps_pkg::in_item_t in_item,
  output logic                   req_valid,
  input  wire logic              req_ready,
  output mps_pkg::in_item_t      req_item
);
  mps_pkg::in_item_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req_item  = q_r[rd_r];
  assign push = in_valid && in_ready;
  assign pop  = req_valid && req_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= in_item;
  end
endmodule
`default_nettype wire

// ===== rtl/mps_engine.sv =====
// back end: process table, ready queue and policy sequencer
// depends on mps_pkg and the assertion macros
`default_nettype none
`include "multi_policy_process_scheduler_macros.svh"
module mps_engine #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        policy,
  input  wire logic [9:0]        slice_time,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire mps_pkg::in_item_t req_item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output mps_pkg::out_item_t     res_item
);
  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_TIME  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] st_r;
  logic [MAX_PROCS-1:0] ev_r, eb_r;
  logic [2:0] prio_r [MAX_PROCS];
  logic [TIME_BITS-1:0] time_r [MAX_PROCS];
  logic [SW-1:0] ord_r [MAX_PROCS];
  logic [CW-1:0] cnt_r;
  logic          run_v_r;
  logic [SW-1:0] run_s_r;
  mps_pkg::in_item_t req_r;
  logic [CW-1:0] idx_r;     // scan index
  logic [CW-1:0] best_r;    // best / found position
  logic [CW-1:0] take_r;    // shift position
  logic          push_run_r; // after take, push old running slot
  logic [SW-1:0] old_run_r;
  logic [1:0]    status_r;
  logic [SW-1:0] asg_r;
  logic          out_v_r;
  mps_pkg::out_item_t out_r;

  // lowest free slot
  logic [SW-1:0] free_s;
  logic          free_any;
  always_comb begin
    free_s = '0;
    free_any = 1'b0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (!ev_r[i]) begin
        free_s = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic [SW-1:0] pid_s;
  logic          pid_in;
  assign pid_in = ({28'd0, req_item.process_id} < 32'(MAX_PROCS));
  assign pid_s  = SW'(req_item.process_id);

  logic [SW-1:0] scan_slot, best_slot;
  assign scan_slot = ord_r[idx_r[SW-1:0]];
  assign best_slot = ord_r[best_r[SW-1:0]];

  logic [TIME_BITS-1:0] cur_t, room;
  assign cur_t = time_r[run_s_r];
  assign room  = TMAX - cur_t;

  assign req_ready = (st_r == S_IDLE) && !out_v_r;
  assign res_valid = out_v_r;
  assign res_item  = out_r;

  function automatic logic pid_ok(input logic [3:0] p);
    pid_ok = ({28'd0, p} < 32'(MAX_PROCS));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ev_r <= '0;
      eb_r <= '0;
      cnt_r <= '0;
      run_v_r <= 1'b0;
      run_s_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && res_ready) out_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            req_r <= req_item;
            status_r <= mps_pkg::ST_OK;
            asg_r <= '0;
            idx_r <= CW'(1);
            best_r <= '0;
            push_run_r <= 1'b0;
            st_r <= S_OUT;
            case (req_item.req_type)
              mps_pkg::REQ_TICK: begin
                unique case (policy)
                  mps_pkg::POL_FCFS: begin
                    if (!run_v_r && cnt_r != '0) begin
                      take_r <= '0; old_run_r <= ord_r[0]; st_r <= S_SHIFT;
                    end else if (run_v_r) st_r <= S_TIME;
                  end
                  mps_pkg::POL_NPRI: begin
                    if (!run_v_r && cnt_r != '0) st_r <= S_SCAN;
                    else if (run_v_r) st_r <= S_TIME;
                  end
                  mps_pkg::POL_PPRI: begin
                    if (cnt_r != '0) st_r <= S_SCAN;
                    else if (run_v_r) st_r <= S_TIME;
                  end
                  default: begin
                    if (cnt_r != '0) begin
                      take_r <= '0;
                      push_run_r <= run_v_r;
                      old_run_r <= ord_r[0];
                      if (run_v_r) st_r <= S_TIME;
                      else st_r <= S_SHIFT;
                    end
                  end
                endcase
              end
              mps_pkg::REQ_CREATE: begin
                if (!free_any) status_r <= mps_pkg::ST_FULL;
                else begin
                  ev_r[free_s] <= 1'b1;
                  eb_r[free_s] <= 1'b0;
                  prio_r[free_s] <= req_item.priority_req;
                  time_r[free_s] <= '0;
                  ord_r[cnt_r[SW-1:0]] <= free_s;
                  cnt_r <= cnt_r + 1'b1;
                  asg_r <= free_s;
                end
              end
              mps_pkg::REQ_BLOCK: begin
                if (!run_v_r) status_r <= mps_pkg::ST_NO_RUN;
                else begin
                  eb_r[run_s_r] <= 1'b1;
                  run_v_r <= 1'b0;
                end
              end
              mps_pkg::REQ_WAKE: begin
                if (pid_in && ev_r[pid_s] && eb_r[pid_s]) begin
                  eb_r[pid_s] <= 1'b0;
                  ord_r[cnt_r[SW-1:0]] <= pid_s;
                  cnt_r <= cnt_r + 1'b1;
                end else status_r <= mps_pkg::ST_NOT_FND;
              end
              mps_pkg::REQ_TERM: begin
                if (run_v_r && pid_in && run_s_r == pid_s) begin
                  ev_r[pid_s] <= 1'b0;
                  run_v_r <= 1'b0;
                end else begin
                  idx_r <= '0;
                  st_r <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (req_r.req_type == mps_pkg::REQ_TERM) begin
            if (idx_r < cnt_r && {{(32-SW){1'b0}}, scan_slot} ==
                {28'd0, req_r.process_id}) begin
              ev_r[scan_slot] <= 1'b0;
              take_r <= idx_r;
              st_r <= S_SHIFT;
            end else if (idx_r + 1'b1 >= cnt_r || idx_r >= cnt_r) begin
              if (pid_ok(req_r.process_id) && ev_r[SW'(req_r.process_id)] &&
                  eb_r[SW'(req_r.process_id)]) begin
                ev_r[SW'(req_r.process_id)] <= 1'b0;
                eb_r[SW'(req_r.process_id)] <= 1'b0;
              end else status_r <= mps_pkg::ST_NOT_FND;
              st_r <= S_OUT;
            end else idx_r <= idx_r + 1'b1;
          end else begin
            if (idx_r < cnt_r) begin
              if (prio_r[scan_slot] < prio_r[best_slot]) best_r <= idx_r;
              idx_r <= idx_r + 1'b1;
            end else begin
              take_r <= best_r;
              old_run_r <= best_slot;
              if (policy == mps_pkg::POL_PPRI && run_v_r) begin
                if (prio_r[best_slot] < prio_r[run_s_r]) begin
                  push_run_r <= 1'b1;
                  st_r <= S_SHIFT;
                end else st_r <= S_TIME;
              end else st_r <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          // one queue entry moves down per cycle
          if (take_r + 1'b1 < cnt_r) begin
            ord_r[take_r[SW-1:0]] <= ord_r[SW'(take_r + 1'b1)];
            take_r <= take_r + 1'b1;
          end else begin
            if (req_r.req_type == mps_pkg::REQ_TERM) begin
              cnt_r <= cnt_r - 1'b1;
              st_r <= S_OUT;
            end else begin
              if (push_run_r) ord_r[take_r[SW-1:0]] <= run_s_r;
              else cnt_r <= cnt_r - 1'b1;
              run_s_r <= old_run_r;
              run_v_r <= 1'b1;
              if (policy == mps_pkg::POL_RR) st_r <= S_OUT;
              else st_r <= S_TIME;
            end
          end
        end
        S_TIME: begin
          if ({{(TIME_BITS>10?TIME_BITS-10:0){1'b0}}, slice_time} > room)
            time_r[run_s_r] <= TMAX;
          else
            time_r[run_s_r] <= cur_t + TIME_BITS'(slice_time);
          if (policy == mps_pkg::POL_RR) st_r <= S_SHIFT;
          else st_r <= S_OUT;
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          out_r.status <= status_r;
          out_r.assigned_id <= 4'(asg_r);
          out_r.running_valid <= run_v_r;
          out_r.running_id <= run_v_r ? 4'(run_s_r) : 4'd0;
          out_r.running_time <= run_v_r ? 32'(cur_t) : 32'd0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `MPS_ASSERT(a_cnt_range, clk, rst_n, (cnt_r <= CW'(MAX_PROCS)))
  `MPS_ASSERT(a_run_valid_slot, clk, rst_n, (run_v_r |-> ev_r[run_s_r]))
  `MPS_ASSERT(a_out_after_state, clk, rst_n, ($rose(out_v_r) |-> $past(st_r) == S_OUT))
endmodule
`default_nettype wire

// ===== rtl/multi_policy_process_scheduler.sv =====
// top level of the multi-policy process scheduler
// depends on mps_pkg, mps_front and mps_engine
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_ready  | in_item  (req_type, process_id, priority_req)
//  out_    | out | out_valid/out_ready| out_item (status, ids, running_time)
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// ticks under priority policies scan the ready queue (one entry a cycle) and
// compacting the queue moves one entry a cycle, so a transaction takes longer
// the more entries the ready queue holds
// reset is synchronous, active low; it empties the table and queue
// a two-entry request queue takes up to two transactions while the engine works
`default_nettype none
module multi_policy_process_scheduler #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mps_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mps_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [9:0]         cfg_wdata
);
  logic [1:0] policy_r;
  logic [9:0] slice_r;
  logic       req_valid, req_ready;
  mps_pkg::in_item_t req_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= mps_pkg::POL_FCFS;
      slice_r  <= 10'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        mps_pkg::CFG_POLICY: policy_r <= cfg_wdata[1:0];
        default:             slice_r  <= cfg_wdata;
      endcase
    end
  end

  mps_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item)
  );

  mps_engine #(.MAX_PROCS(MAX_PROCS), .TIME_BITS(TIME_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .policy(policy_r), .slice_time(slice_r),
    .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
    .res_valid(out_valid), .res_ready(out_ready), .res_item(out_item)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for multi_policy_process_scheduler: predicts every answer
// from a cycle-free copy of the scheduler state; depends on mps_pkg and the rtl
module tb;
  import mps_pkg::*;

  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int NUM_SLOTS = 16;
  localparam int PHASE_ITEMS = 203;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 3000;    // cycles with no transaction at all

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_POLICY;
  logic [9:0] cfg_wdata = '0;

  multi_policy_process_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow copy of the scheduler
  logic [1:0] sh_policy = POL_FCFS;
  logic [9:0] sh_slice = 10'd50;
  logic sh_valid [NUM_SLOTS];
  logic sh_blocked [NUM_SLOTS];
  logic [2:0] sh_prio [NUM_SLOTS];
  logic [31:0] sh_time [NUM_SLOTS];
  logic [3:0] ready_fifo [$];
  logic sh_run_valid = 1'b0;
  logic [3:0] sh_run_slot = '0;

  in_item_t req_backlog [$];     // requests waiting for the driver
  out_item_t sched_answers [$];  // answers the block still owes
  int errors = 0;
  int idle_cycles = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sh_valid[i] = 1'b0;
      sh_blocked[i] = 1'b0;
    end
  end

  // saturating run-time update
  function automatic void charge_slice(input logic [3:0] s);
    logic [32:0] sum;
    sum = {1'b0, sh_time[s]} + sh_slice;
    sh_time[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // position of the best priority in the ready fifo, first entry wins ties
  function automatic int best_pos();
    int b;
    b = 0;
    for (int i = 1; i < ready_fifo.size(); i++)
      if (sh_prio[ready_fifo[i]] < sh_prio[ready_fifo[b]]) b = i;
    return b;
  endfunction

  function automatic void run_tick();
    int b;
    logic [3:0] s;
    case (sh_policy)
      POL_FCFS, POL_NPRI: begin
        if (!sh_run_valid && ready_fifo.size() > 0) begin
          b = (sh_policy == POL_FCFS) ? 0 : best_pos();
          sh_run_slot = ready_fifo[b];
          ready_fifo.delete(b);
          sh_run_valid = 1'b1;
        end
        if (sh_run_valid) charge_slice(sh_run_slot);
      end
      POL_PPRI: begin
        if (ready_fifo.size() > 0) begin
          b = best_pos();
          s = ready_fifo[b];
          if (!sh_run_valid || sh_prio[s] < sh_prio[sh_run_slot]) begin
            ready_fifo.delete(b);
            if (sh_run_valid) ready_fifo.push_back(sh_run_slot);
            sh_run_slot = s;
            sh_run_valid = 1'b1;
          end
        end
        if (sh_run_valid) charge_slice(sh_run_slot);
      end
      default: begin
        // round robin only moves when someone is waiting
        if (ready_fifo.size() > 0) begin
          if (sh_run_valid) begin
            charge_slice(sh_run_slot);
            ready_fifo.push_back(sh_run_slot);
          end
          sh_run_slot = ready_fifo.pop_front();
          sh_run_valid = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic out_item_t schedule_step(input in_item_t rq);
    out_item_t a;
    int free_slot;
    int pos;
    a = '0;
    a.status = ST_OK;
    case (rq.req_type)
      REQ_TICK: run_tick();
      REQ_CREATE: begin
        free_slot = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
          if (!sh_valid[i]) free_slot = i;
        if (free_slot < 0) a.status = ST_FULL;
        else begin
          sh_valid[free_slot] = 1'b1;
          sh_prio[free_slot] = rq.priority_req;
          sh_time[free_slot] = '0;
          sh_blocked[free_slot] = 1'b0;
          ready_fifo.push_back(4'(free_slot));
          a.assigned_id = 4'(free_slot);
        end
      end
      REQ_BLOCK: begin
        if (!sh_run_valid) a.status = ST_NO_RUN;
        else begin
          sh_blocked[sh_run_slot] = 1'b1;
          sh_run_valid = 1'b0;
        end
      end
      REQ_WAKE: begin
        if (sh_valid[rq.process_id] && sh_blocked[rq.process_id]) begin
          sh_blocked[rq.process_id] = 1'b0;
          ready_fifo.push_back(rq.process_id);
        end else a.status = ST_NOT_FND;
      end
      REQ_TERM: begin
        pos = -1;
        foreach (ready_fifo[i]) if (pos < 0 && ready_fifo[i] == rq.process_id) pos = i;
        if (sh_run_valid && sh_run_slot == rq.process_id) begin
          sh_valid[rq.process_id] = 1'b0;
          sh_run_valid = 1'b0;
        end else if (pos >= 0) begin
          ready_fifo.delete(pos);
          sh_valid[rq.process_id] = 1'b0;
        end else if (sh_valid[rq.process_id] && sh_blocked[rq.process_id]) begin
          sh_valid[rq.process_id] = 1'b0;
          sh_blocked[rq.process_id] = 1'b0;
        end else a.status = ST_NOT_FND;
      end
      default: ;  // spare codes change nothing
    endcase
    a.running_valid = sh_run_valid;
    a.running_id = sh_run_valid ? sh_run_slot : 4'd0;
    a.running_time = sh_run_valid ? sh_time[sh_run_slot] : 32'd0;
    return a;
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver: one nonblocking update of in_valid per edge
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // accepted transaction feeds the predictor
      if (in_valid && in_ready) sched_answers.push_back(schedule_step(in_item));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          in_item <= req_backlog.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each answer with the oldest prediction
  int hold_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sched_answers.size() == 0) begin
          report("unexpected transaction", 32'd0, 32'd0);
        end else begin
          out_item_t e;
          e = sched_answers.pop_front();
          if (out_item.status !== e.status) report("status", out_item.status, e.status);
          if (out_item.assigned_id !== e.assigned_id)
            report("assigned_id", out_item.assigned_id, e.assigned_id);
          if (out_item.running_valid !== e.running_valid)
            report("running_valid", out_item.running_valid, e.running_valid);
          if (out_item.running_id !== e.running_id)
            report("running_id", out_item.running_id, e.running_id);
          if (out_item.running_time !== e.running_time)
            report("running_time", out_item.running_time, e.running_time);
        end
      end
      // stalls come in bursts, with long runs of none
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) hold_gap = pick_gap();
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d answers outstanding", sched_answers.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_POLICY) sh_policy = val[1:0];
    else sh_slice = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block is idle once nothing is queued or owed, plus its own latency
  // sampled at the falling edge so the driver's updates have settled
  task automatic wait_quiet();
    while (req_backlog.size() != 0 || in_valid || sched_answers.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_req(input logic [2:0] t, input logic [3:0] id, input logic [2:0] pr);
    in_item_t it;
    it.req_type = t;
    it.process_id = id;
    it.priority_req = pr;
    req_backlog.push_back(it);
  endtask

  // creates outweigh terminates so the table fills up now and then
  task automatic queue_random(input int count);
    int r;
    logic [2:0] t;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25) t = REQ_TICK;
      else if (r < 55) t = REQ_CREATE;
      else if (r < 65) t = REQ_BLOCK;
      else if (r < 80) t = REQ_WAKE;
      else if (r < 96) t = REQ_TERM;
      else t = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      queue_req(t, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
    end
  endtask

  logic [1:0] phase_policy [8] = '{POL_NPRI, POL_PPRI, POL_RR, POL_FCFS,
                                   POL_PPRI, POL_RR, POL_NPRI, POL_PPRI};
  logic [9:0] phase_slice [8] = '{10'd1, 10'd1023, 10'd0, 10'd1000,
                                  10'd7, 10'd50, 10'd0, 10'd300};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under reset settings (fcfs, slice 50)
    queue_req(REQ_BLOCK, 4'd0, 3'd0);        // nothing running
    queue_req(REQ_TICK, 4'd15, 3'd7);        // tick with empty queue
    queue_req(REQ_CREATE, 4'd0, 3'd0);
    queue_req(REQ_CREATE, 4'd0, 3'd7);       // largest priority codes kept
    queue_req(REQ_CREATE, 4'd0, 3'd6);
    queue_req(REQ_CREATE, 4'd15, 3'd5);
    queue_req(REQ_TICK, 4'd0, 3'd0);         // dispatch head
    queue_req(REQ_TICK, 4'd0, 3'd0);
    queue_req(REQ_BLOCK, 4'd0, 3'd0);
    queue_req(REQ_WAKE, 4'd0, 3'd0);         // blocked process back to tail
    queue_req(REQ_WAKE, 4'd15, 3'd0);        // free slot
    queue_req(REQ_WAKE, 4'd1, 3'd0);         // ready, not blocked
    queue_req(REQ_TICK, 4'd0, 3'd0);
    queue_req(REQ_TERM, 4'd1, 3'd0);         // running one
    queue_req(REQ_TERM, 4'd2, 3'd0);         // ready one
    queue_req(REQ_TICK, 4'd0, 3'd0);
    queue_req(REQ_BLOCK, 4'd0, 3'd0);
    queue_req(REQ_TERM, 4'd3, 3'd0);         // blocked one
    queue_req(REQ_TERM, 4'd3, 3'd0);         // already gone
    queue_req(REQ_SPARE_LO, 4'd9, 3'd2);
    queue_req(REQ_SPARE_HI, 4'd15, 3'd7);
    queue_req(REQ_CREATE, 4'd0, 3'd3);       // reuses lowest free slot
    queue_req(REQ_TERM, 4'd15, 3'd0);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_POLICY, {8'd0, phase_policy[p]});
      write_reg(CFG_SLICE, (p == 7) ? 10'($urandom_range(1, 1023)) : phase_slice[p]);
      queue_random(PHASE_ITEMS);
      wait_quiet();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mps_pkg.sv
rtl/mps_front.sv
rtl/mps_engine.sv
rtl/multi_policy_process_scheduler.sv
tb/sv/tb.sv
